### hdl/variable_length_lru_column_cache_top_assert.svh
// Assertion macros used by the column cache RTL.
`ifndef VARIABLE_LENGTH_LRU_COLUMN_CACHE_TOP_ASSERT_SVH
`define VARIABLE_LENGTH_LRU_COLUMN_CACHE_TOP_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define VLLC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that implies another one at the next clock edge.
`define VLLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/vllc_pkg.sv
// ----------------------------------------------------------------------------
// vllc_pkg
// Types and constants of the variable-length LRU column cache.
// ----------------------------------------------------------------------------
package vllc_pkg;

   localparam int ID_W  = 12;
   localparam int LEN_W = 9;
   localparam int CAP_W = 17;

   localparam logic [1:0] CMD_GET   = 2'd0;
   localparam logic [1:0] CMD_SWAP  = 2'd1;
   localparam logic [1:0] CMD_CHECK = 2'd2;

   localparam logic [LEN_W-1:0] LEN_LIMIT = 9'd256;
   localparam logic [CAP_W-1:0] CAP_RESET = 17'd65536;

   typedef struct packed {
      logic [1:0]       cmd;
      logic [7:0]       index_a;
      logic [7:0]       index_b;
      logic [LEN_W-1:0] req_len;
   } req_type;

   typedef struct packed {
      logic [LEN_W-1:0] prior_len;
      logic             hit;
      logic [LEN_W-1:0] evicted_count;
      logic [CAP_W-1:0] free_left;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [LEN_W-1:0] len;
   } entry_type;

   typedef struct packed {
      logic            pop;
      logic            push;
      logic [ID_W-1:0] tail;
   } chain_ctl_type;

endpackage

### hdl/variable_length_lru_column_cache_top.sv
// ----------------------------------------------------------------------------
// variable_length_lru_column_cache_top
// Metadata keeper for a kernel column cache with an element budget.
// ----------------------------------------------------------------------------
// Usage: a request transaction (get, swap or check) is taken on req_* when
// req_valid is high and req_stall is low. Exactly one response transaction
// follows on rsp_*, taken when rsp_valid is high and rsp_stall is low.
// The cached columns sit in a chain of cells in LRU order; lookups are
// done by rotating the chain one entry per cycle through its head cell.
// A check rotates the list once. A get rotates it, evicts the oldest columns
// while the grown length does not fit in the budget, and pushes the column
// back at the tail. A swap of two columns rotates the list, pushes both back
// and walks it once more to drop the lengths between them; a column swapped
// with itself is done after the rotation. One request is in work at a
// time; req_stall is high while a request is in progress or a budget write
// is offered. The response sits in an output register, so a new request is
// accepted while the previous response still waits on a stalled receiver.
// Synchronous reset empties the cache and sets the budget to 65536; a write
// on csr_* (taken while idle, csr_ready high) sets the budget and empties
// the cache in the same cycle.
// ----------------------------------------------------------------------------
module variable_length_lru_column_cache_top #(
   parameter int NUM_COLUMNS = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  vllc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output vllc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [16:0]       csr_data
);
   import vllc_pkg::*;

   localparam int CNT_W = $clog2(NUM_COLUMNS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SCAN1 = 3'd1;
   localparam logic [2:0] ST_EVICT = 3'd2;
   localparam logic [2:0] ST_PUSHA = 3'd3;
   localparam logic [2:0] ST_PUSHB = 3'd4;
   localparam logic [2:0] ST_SCAN2 = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   logic [7:0]       a_ff, a_in, b_ff, b_in;
   logic [LEN_W-1:0] rl_ff, rl_in, la_ff, la_in, lb_ff, lb_in;
   logic [LEN_W-1:0] more_ff, more_in, push_len_ff, push_len_in;
   logic [LEN_W-1:0] prior_ff, prior_in, evict_ff, evict_in;
   logic             hit_ff, hit_in;
   logic [CAP_W-1:0] cap_ff, cap_in, free_ff, free_in;
   logic [CNT_W-1:0] count_ff, count_in, remain_ff, remain_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   chain_ctl_type ctl;
   entry_type     push_entry, head;
   logic          req_accept, csr_accept;
   logic [ID_W-1:0] a_id, b_id;
   logic [7:0]      lo, hi;
   logic [LEN_W-1:0] rl_clamp;

   vllc_chain #(.NUM_COLUMNS(NUM_COLUMNS)) u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .push_entry (push_entry),
      .head       (head)
   );

   assign req_accept = req_valid && !req_stall;
   assign csr_accept = csr_valid && csr_ready;
   // A budget write takes priority, so a request offered with it is held off.
   assign req_stall  = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign a_id = ID_W'(a_ff);
   assign b_id = ID_W'(b_ff);
   assign lo   = (a_ff < b_ff) ? a_ff : b_ff;
   assign hi   = (a_ff < b_ff) ? b_ff : a_ff;

   // A zero length counts as one element, anything above the limit as the limit.
   always_comb begin
      rl_clamp = req_data.req_len;
      if (rl_clamp == '0) begin
         rl_clamp = 9'd1;
      end else if (rl_clamp > LEN_LIMIT) begin
         rl_clamp = LEN_LIMIT;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      rl_in        = rl_ff;
      la_in        = la_ff;
      lb_in        = lb_ff;
      more_in      = more_ff;
      push_len_in  = push_len_ff;
      prior_in     = prior_ff;
      evict_in     = evict_ff;
      hit_in       = hit_ff;
      cap_in       = cap_ff;
      free_in      = free_ff;
      remain_in    = remain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      ctl.pop      = 1'b0;
      ctl.push     = 1'b0;
      push_entry   = head;

      case (state_ff)
         ST_IDLE: begin
            if (csr_accept) begin
               cap_in  = csr_data;
               free_in = csr_data;
            end else if (req_accept) begin
               op_in     = req_data.cmd;
               a_in      = req_data.index_a;
               b_in      = req_data.index_b;
               rl_in     = rl_clamp;
               la_in     = '0;
               lb_in     = '0;
               prior_in  = '0;
               hit_in    = 1'b0;
               evict_in  = '0;
               remain_in = count_ff;
               state_in  = ST_DONE;
               if ((req_data.cmd == CMD_GET || req_data.cmd == CMD_CHECK) &&
                   (32'(req_data.index_a) < NUM_COLUMNS)) begin
                  state_in = ST_SCAN1;
               end else if (req_data.cmd == CMD_SWAP &&
                            (32'(req_data.index_a) < NUM_COLUMNS) &&
                            (32'(req_data.index_b) < NUM_COLUMNS)) begin
                  state_in = ST_SCAN1;
               end
            end
         end
         ST_SCAN1: begin
            // Rotate the whole list once, pulling out the columns in question for a get or a swap of two columns.
            if (remain_ff != '0) begin
               ctl.pop   = 1'b1;
               remain_in = remain_ff - 1'b1;
               ctl.push  = 1'b1;
               if (head.id == a_id) begin
                  la_in = head.len;
               end
               if (op_ff == CMD_SWAP && head.id == b_id) begin
                  lb_in = head.len;
               end
               if (op_ff == CMD_GET && head.id == a_id) begin
                  ctl.push = 1'b0;
               end
               if (op_ff == CMD_SWAP && a_ff != b_ff &&
                   (head.id == a_id || head.id == b_id)) begin
                  ctl.push = 1'b0;
               end
            end else begin
               case (op_ff)
                  CMD_GET: begin
                     if (rl_ff > la_ff) begin
                        more_in     = rl_ff - la_ff;
                        push_len_in = rl_ff;
                        prior_in    = la_ff;
                        state_in    = ST_EVICT;
                     end else begin
                        push_len_in = la_ff;
                        prior_in    = rl_ff;
                        state_in    = ST_PUSHA;
                     end
                  end
                  CMD_CHECK: begin
                     prior_in = la_ff;
                     hit_in   = (la_ff > {1'b0, b_ff});
                     state_in = ST_DONE;
                  end
                  default: begin
                     if (a_ff == b_ff) begin
                        prior_in = la_ff;
                        state_in = ST_DONE;
                     end else begin
                        push_len_in = lb_ff;
                        prior_in    = lb_ff;
                        state_in    = ST_PUSHA;
                     end
                  end
               endcase
            end
         end
         ST_EVICT: begin
            // Drop the oldest columns until the growth fits in the budget or the list is empty.
            if (free_ff < CAP_W'(more_ff) && count_ff != '0) begin
               ctl.pop  = 1'b1;
               free_in  = free_ff + CAP_W'(head.len);
               evict_in = evict_ff + 1'b1;
            end else begin
               free_in  = (free_ff >= CAP_W'(more_ff)) ? free_ff - CAP_W'(more_ff) : '0;
               state_in = ST_PUSHA;
            end
         end
         ST_PUSHA: begin
            push_entry.id  = a_id;
            push_entry.len = push_len_ff;
            ctl.push       = (push_len_ff != '0);
            state_in       = (op_ff == CMD_SWAP) ? ST_PUSHB : ST_DONE;
         end
         ST_PUSHB: begin
            push_entry.id  = b_id;
            push_entry.len = la_ff;
            ctl.push       = (la_ff != '0);
            remain_in      = count_ff + CNT_W'(la_ff != '0);
            state_in       = ST_SCAN2;
         end
         ST_SCAN2: begin
            // Walk the list once, dropping lengths that cover lo but not hi.
            if (remain_ff != '0) begin
               ctl.pop   = 1'b1;
               remain_in = remain_ff - 1'b1;
               if (head.len > {1'b0, lo} && head.len <= {1'b0, hi}) begin
                  free_in  = free_ff + CAP_W'(head.len);
                  evict_in = evict_ff + 1'b1;
                  if (head.id == a_id) begin
                     prior_in = '0;
                  end
               end else begin
                  ctl.push = 1'b1;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in         = 1'b1;
               rsp_in.prior_len     = prior_ff;
               rsp_in.hit           = hit_ff;
               rsp_in.evicted_count = evict_ff;
               rsp_in.free_left     = free_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      ctl.tail = ctl.pop ? ID_W'(count_ff - 1'b1) : ID_W'(count_ff);
      count_in = count_ff - CNT_W'(ctl.pop) + CNT_W'(ctl.push);
      if (state_ff == ST_IDLE && csr_accept) begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
         free_ff      <= CAP_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
         free_ff      <= free_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      rl_ff       <= rl_in;
      la_ff       <= la_in;
      lb_ff       <= lb_in;
      more_ff     <= more_in;
      push_len_ff <= push_len_in;
      prior_ff    <= prior_in;
      evict_ff    <= evict_in;
      hit_ff      <= hit_in;
      remain_ff   <= remain_in;
      rsp_ff      <= rsp_in;
   end

`include "variable_length_lru_column_cache_top_assert.svh"

   `VLLC_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(NUM_COLUMNS), "list overflow")
   `VLLC_ASSERT_ALWAYS(a_remain_bound, clock, reset, remain_ff <= count_ff || state_ff == ST_IDLE || state_ff == ST_DONE, "rotation longer than list")
   `VLLC_ASSERT_NEXT(a_csr_clears, clock, reset, csr_accept, count_ff == '0 && free_ff == cap_ff, "budget write did not empty cache")
   `VLLC_ASSERT_NEXT(a_req_busy, clock, reset, req_accept, state_ff != ST_IDLE, "request not started")
endmodule

### hdl/vllc_cell.sv
// ----------------------------------------------------------------------------
// vllc_cell
// One slot of the LRU chain: holds a column id and its cached length.
// ----------------------------------------------------------------------------
module vllc_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                    clock,
   input  vllc_pkg::chain_ctl_type ctl,
   input  vllc_pkg::entry_type     push_entry,
   input  vllc_pkg::entry_type     next_entry,
   output vllc_pkg::entry_type     entry
);
   import vllc_pkg::*;

   entry_type entry_ff, entry_in;
   logic      load;

   // The slot at the tail takes the pushed entry; on a pop every other slot
   // takes its newer neighbor, and the last slot keeps its own entry.
   assign load = ctl.push && (ctl.tail == ID_W'(CELL_INDEX));

   always_comb begin
      entry_in = entry_ff;
      if (load) begin
         entry_in = push_entry;
      end else if (ctl.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
endmodule

### hdl/vllc_chain.sv
// ----------------------------------------------------------------------------
// vllc_chain
// Shifting row of cells kept in LRU order, oldest entry at slot zero.
// ----------------------------------------------------------------------------
module vllc_chain #(
   parameter int NUM_COLUMNS = 256
) (
   input  logic                    clock,
   input  vllc_pkg::chain_ctl_type ctl,
   input  vllc_pkg::entry_type     push_entry,
   output vllc_pkg::entry_type     head
);
   import vllc_pkg::*;

   entry_type slots [NUM_COLUMNS];

   for (genvar i = 0; i < NUM_COLUMNS; i++) begin : g_cell
      entry_type nxt;
      if (i == NUM_COLUMNS - 1) begin : g_last
         assign nxt = slots[i];
      end else begin : g_mid
         assign nxt = slots[i+1];
      end
      vllc_cell #(.CELL_INDEX(i)) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .push_entry (push_entry),
         .next_entry (nxt),
         .entry      (slots[i])
      );
   end

   assign head = slots[0];
endmodule
